// ===== hw/rtl/ppr_pkg.sv =====
// Shared types and constants for the point projection pipeline.
`default_nettype none
package ppr_pkg;

    localparam int COORD_W = 32;
    localparam int QBITS = 21;
    localparam int DXY_W = 22;
    localparam int DIV_LAT = QBITS + 2;
    localparam int COEF_W = 18;
    localparam int CFG_W = 24;
    localparam int PIX_U_W = 11;
    localparam int PIX_V_W = 10;
    localparam int NORM_W = 17;

    localparam logic [2:0] CFG_K1 = 3'd0;
    localparam logic [2:0] CFG_K2 = 3'd1;
    localparam logic [2:0] CFG_K3 = 3'd2;
    localparam logic [2:0] CFG_FX = 3'd3;
    localparam logic [2:0] CFG_FY = 3'd4;
    localparam logic [2:0] CFG_CX = 3'd5;
    localparam logic [2:0] CFG_CY = 3'd6;

    typedef struct packed {
        logic signed [COORD_W-1:0] depth;
        logic                      last;
        logic                      invalid;
    } side_t;

endpackage
`default_nettype wire

// ===== hw/rtl/point_projection_radial_distortion.sv =====
// Top level of the point projection pipeline with radial distortion.
// Throughput: one point per cycle; busy stays low, the pipeline never stalls.
// The 21-stage divider and the multiply chain set the depth.
// Reset clears the pipeline valid bits and loads the default intrinsics.
`default_nettype none
module point_projection_radial_distortion #(
    parameter int IMAGE_WIDTH  = 1280,
    parameter int IMAGE_HEIGHT = 720
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [ppr_pkg::COORD_W-1:0] point_x,
    input  logic signed [ppr_pkg::COORD_W-1:0] point_y,
    input  logic signed [ppr_pkg::COORD_W-1:0] point_z,
    input  logic                               last_point,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [2:0]                         cfg_index,
    input  logic [ppr_pkg::CFG_W-1:0]          cfg_data,
    output logic                               done,
    output logic [ppr_pkg::PIX_U_W-1:0]        pixel_u,
    output logic [ppr_pkg::PIX_V_W-1:0]        pixel_v,
    output logic signed [ppr_pkg::NORM_W-1:0]  norm_x,
    output logic signed [ppr_pkg::NORM_W-1:0]  norm_y,
    output logic signed [ppr_pkg::COORD_W-1:0] depth_out,
    output logic                               invalid,
    output logic                               last_out
);
    import ppr_pkg::*;

    localparam int UW = $clog2(IMAGE_WIDTH);
    localparam int VW = $clog2(IMAGE_HEIGHT);
    localparam int NSTG = 12;
    localparam int LATENCY = 1 + DIV_LAT + NSTG;
    localparam logic signed [39:0] PXMAX = 40'((IMAGE_WIDTH - 1) * 256);
    localparam logic signed [39:0] PYMAX = 40'((IMAGE_HEIGHT - 1) * 256);
    localparam logic signed [48:0] MLIM = 49'sd16777216;

    typedef struct packed {
        logic signed [DXY_W-1:0] dx;
        logic signed [DXY_W-1:0] dy;
        side_t                   side;
    } carry_t;

    logic signed [COEF_W-1:0] k1_reg, k2_reg, k3_reg;
    logic [CFG_W-1:0]         fx_reg, fy_reg, cx_reg, cy_reg;

    logic                        v1_reg;
    logic signed [COORD_W-1:0]   x1_reg, y1_reg, z1_reg;
    side_t                       side1_reg;
    logic                        dv;
    logic signed [DXY_W-1:0]     ddx, ddy;
    side_t                       dside;

    logic [NSTG-2:0]             vp_reg;
    carry_t                      ca_reg, cb_reg, cc_reg, cd_reg, ce_reg, cf_reg, cg_reg;
    side_t                       ch_reg, sh_i_reg, sj_reg, sk_reg;

    logic signed [43:0]          sqx_full, sqy_full;
    logic [40:0]                 sqx_reg, sqy_reg;
    logic [41:0]                 sq_sum;
    logic [25:0]                 r2b_reg, r2c_reg, r2d_reg;
    logic [51:0]                 r4_full;
    logic [34:0]                 r4c_reg, r4d_reg;
    logic [60:0]                 r6_full;
    logic [43:0]                 r6d_reg;
    logic signed [44:0]          kr2d_reg, kr2e_reg;
    logic signed [53:0]          kr4e_reg;
    logic signed [62:0]          kr6e_reg;
    logic signed [63:0]          sumf_reg;
    logic signed [48:0]          msum;
    logic signed [25:0]          m_next, mg_reg;
    logic signed [47:0]          prx, pry;
    logic signed [29:0]          sxh_reg, syh_reg;
    logic signed [54:0]          fpx, fpy;
    logic signed [38:0]          fxi_reg, fyi_reg;
    logic signed [39:0]          px, py;
    logic [UW-1:0]               u_next, u_reg, uk_reg;
    logic [VW-1:0]               v_next, v_reg, vk_reg;
    logic signed [NORM_W-1:0]    nx, ny;

    logic                        done_reg;
    logic [PIX_U_W-1:0]          pixel_u_reg;
    logic [PIX_V_W-1:0]          pixel_v_reg;
    side_t                       sout_reg;

    assign busy = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k1_reg <= 18'sd14977;
            k2_reg <= -18'sd43452;
            k3_reg <= 18'sd42134;
            fx_reg <= 24'd266941;
            fy_reg <= 24'd267000;
            cx_reg <= 24'd163142;
            cy_reg <= 24'd90350;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_K1:  k1_reg <= $signed(cfg_data[COEF_W-1:0]);
                CFG_K2:  k2_reg <= $signed(cfg_data[COEF_W-1:0]);
                CFG_K3:  k3_reg <= $signed(cfg_data[COEF_W-1:0]);
                CFG_FX:  fx_reg <= cfg_data;
                CFG_FY:  fy_reg <= cfg_data;
                CFG_CX:  cx_reg <= cfg_data;
                CFG_CY:  cy_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        x1_reg <= point_x;
        y1_reg <= point_y;
        z1_reg <= point_z;
        side1_reg <= '{depth: point_z, last: last_point, invalid: (point_z == '0)};
    end

    ppr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (v1_reg),
        .num_x    (x1_reg),
        .num_y    (y1_reg),
        .den      (z1_reg),
        .side_in  (side1_reg),
        .out_valid(dv),
        .dx       (ddx),
        .dy       (ddy),
        .side_out (dside)
    );

    always_comb
    begin
        sqx_full = ddx * ddx;
        sqy_full = ddy * ddy;
        sq_sum = {1'b0, sqx_reg} + {1'b0, sqy_reg};
        r4_full = {26'b0, r2b_reg} * {26'b0, r2b_reg};
        r6_full = {26'b0, r4c_reg} * {35'b0, r2c_reg};
        msum = $signed(sumf_reg[63:16]) + 49'sd65536;
        if (msum > MLIM)
            m_next = 26'(MLIM);
        else if (msum < -MLIM)
            m_next = 26'(-MLIM);
        else
            m_next = msum[25:0];
        prx = cg_reg.dx * mg_reg;
        pry = cg_reg.dy * mg_reg;
        fpx = $signed({1'b0, fx_reg}) * sxh_reg;
        fpy = $signed({1'b0, fy_reg}) * syh_reg;
        px = {fxi_reg[38], fxi_reg} + $signed({16'b0, cx_reg});
        py = {fyi_reg[38], fyi_reg} + $signed({16'b0, cy_reg});
        if (sh_i_reg.invalid || px < 40'sd0)
            u_next = '0;
        else if (px > PXMAX)
            u_next = PXMAX[UW+7:8];
        else
            u_next = px[UW+7:8];
        if (sh_i_reg.invalid || py < 40'sd0)
            v_next = '0;
        else if (py > PYMAX)
            v_next = PYMAX[VW+7:8];
        else
            v_next = py[VW+7:8];
    end

    always_ff @(posedge clk)
    begin
        sqx_reg  <= sqx_full[40:0];
        sqy_reg  <= sqy_full[40:0];
        ca_reg   <= '{dx: ddx, dy: ddy, side: dside};
        r2b_reg  <= sq_sum[41:16];
        cb_reg   <= ca_reg;
        r2c_reg  <= r2b_reg;
        r4c_reg  <= r4_full[50:16];
        cc_reg   <= cb_reg;
        r6d_reg  <= r6_full[59:16];
        r4d_reg  <= r4c_reg;
        r2d_reg  <= r2c_reg;
        kr2d_reg <= k1_reg * $signed({1'b0, r2c_reg});
        cd_reg   <= cc_reg;
        kr2e_reg <= kr2d_reg;
        kr4e_reg <= k2_reg * $signed({1'b0, r4d_reg});
        kr6e_reg <= k3_reg * $signed({1'b0, r6d_reg});
        ce_reg   <= cd_reg;
        sumf_reg <= 64'(kr2e_reg) + 64'(kr4e_reg) + 64'(kr6e_reg);
        cf_reg   <= ce_reg;
        mg_reg   <= m_next;
        cg_reg   <= cf_reg;
        ch_reg   <= cg_reg.side;
        sxh_reg  <= prx[45:16];
        syh_reg  <= pry[45:16];
        sh_i_reg <= ch_reg;
        fxi_reg  <= fpx[54:16];
        fyi_reg  <= fpy[54:16];
        sj_reg   <= sh_i_reg;
        u_reg    <= u_next;
        v_reg    <= v_next;
        sk_reg   <= sj_reg;
        uk_reg   <= u_reg;
        vk_reg   <= v_reg;
        pixel_u_reg <= PIX_U_W'(uk_reg);
        pixel_v_reg <= PIX_V_W'(vk_reg);
        sout_reg <= sk_reg;
    end

    ppr_norm #(.SIZE(IMAGE_WIDTH)) u_norm_x (
        .clk (clk),
        .pix (u_reg),
        .norm(nx)
    );

    ppr_norm #(.SIZE(IMAGE_HEIGHT)) u_norm_y (
        .clk (clk),
        .pix (v_reg),
        .norm(ny)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            vp_reg   <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start && !busy;
            vp_reg   <= {vp_reg[NSTG-3:0], dv};
            done_reg <= vp_reg[NSTG-2];
        end
    end

    assign done = done_reg;
    assign pixel_u = pixel_u_reg;
    assign pixel_v = pixel_v_reg;
    assign norm_x = nx;
    assign norm_y = ny;
    assign depth_out = sout_reg.depth;
    assign invalid = sout_reg.invalid;
    assign last_out = sout_reg.last;

    // Every result must trace back to an earlier accepted transaction.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without matching transaction");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && invalid) |-> (pixel_u == '0 && pixel_v == '0 && norm_x == -17'sd65536))
        else $error("invalid point with nonzero pixel");

    a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (32'(pixel_u) < 32'(IMAGE_WIDTH) || IMAGE_WIDTH > 2048))
        else $error("pixel column beyond image");

endmodule
`default_nettype wire

// ===== hw/rtl/ppr_div.sv =====
// Pipelined restoring divider forming saturated x/z and y/z in Q.16, one bit per stage.
`default_nettype none
module ppr_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic signed [ppr_pkg::COORD_W-1:0] num_x,
    input  logic signed [ppr_pkg::COORD_W-1:0] num_y,
    input  logic signed [ppr_pkg::COORD_W-1:0] den,
    input  ppr_pkg::side_t                     side_in,
    output logic                               out_valid,
    output logic signed [ppr_pkg::DXY_W-1:0]   dx,
    output logic signed [ppr_pkg::DXY_W-1:0]   dy,
    output ppr_pkg::side_t                     side_out
);
    import ppr_pkg::*;

    localparam int NUM_W = COORD_W + 16;
    localparam int STG = QBITS;
    localparam int SH_W = COORD_W + QBITS;
    localparam logic [QBITS-1:0] QLIM = QBITS'(2 ** 20);

    logic [COORD_W-1:0] ax;
    logic [COORD_W-1:0] ay;
    logic [COORD_W-1:0] az;

    logic [NUM_W-1:0]   rx_reg [0:STG];
    logic [NUM_W-1:0]   ry_reg [0:STG];
    logic [QBITS-1:0]   qx_reg [0:STG];
    logic [QBITS-1:0]   qy_reg [0:STG];
    logic [COORD_W-1:0] d_reg  [0:STG];
    logic               nx_reg [0:STG];
    logic               ny_reg [0:STG];
    logic               ox_reg [0:STG];
    logic               oy_reg [0:STG];
    side_t              sd_reg [0:STG];
    logic [STG:0]       v_reg;

    logic [QBITS-1:0]        magx;
    logic [QBITS-1:0]        magy;
    logic signed [DXY_W-1:0] dx_next;
    logic signed [DXY_W-1:0] dy_next;
    logic signed [DXY_W-1:0] dx_reg;
    logic signed [DXY_W-1:0] dy_reg;
    side_t                   side_reg;
    logic                    out_valid_reg;

    assign ax = num_x[COORD_W-1] ? (~$unsigned(num_x) + 1'b1) : $unsigned(num_x);
    assign ay = num_y[COORD_W-1] ? (~$unsigned(num_y) + 1'b1) : $unsigned(num_y);
    assign az = den[COORD_W-1] ? (~$unsigned(den) + 1'b1) : $unsigned(den);

    always_ff @(posedge clk)
    begin
        rx_reg[0] <= {ax, 16'b0};
        ry_reg[0] <= {ay, 16'b0};
        qx_reg[0] <= '0;
        qy_reg[0] <= '0;
        d_reg[0]  <= az;
        nx_reg[0] <= num_x[COORD_W-1] ^ den[COORD_W-1];
        ny_reg[0] <= num_y[COORD_W-1] ^ den[COORD_W-1];
        ox_reg[0] <= {5'b0, ax} >= {az, 5'b0};
        oy_reg[0] <= {5'b0, ay} >= {az, 5'b0};
        sd_reg[0] <= side_in;
    end

    for (genvar k = 1; k <= STG; k++)
    begin : g_stage
        localparam int B = STG - k;
        logic [SH_W-1:0] shifted;
        logic            gex;
        logic            gey;

        assign shifted = {{QBITS{1'b0}}, d_reg[k-1]} << B;
        assign gex = {{(SH_W-NUM_W){1'b0}}, rx_reg[k-1]} >= shifted;
        assign gey = {{(SH_W-NUM_W){1'b0}}, ry_reg[k-1]} >= shifted;

        always_ff @(posedge clk)
        begin
            rx_reg[k] <= gex ? rx_reg[k-1] - shifted[NUM_W-1:0] : rx_reg[k-1];
            ry_reg[k] <= gey ? ry_reg[k-1] - shifted[NUM_W-1:0] : ry_reg[k-1];
            qx_reg[k] <= {qx_reg[k-1][QBITS-2:0], gex};
            qy_reg[k] <= {qy_reg[k-1][QBITS-2:0], gey};
            d_reg[k]  <= d_reg[k-1];
            nx_reg[k] <= nx_reg[k-1];
            ny_reg[k] <= ny_reg[k-1];
            ox_reg[k] <= ox_reg[k-1];
            oy_reg[k] <= oy_reg[k-1];
            sd_reg[k] <= sd_reg[k-1];
        end
    end

    always_comb
    begin
        magx = (ox_reg[STG] || qx_reg[STG] > QLIM) ? QLIM : qx_reg[STG];
        magy = (oy_reg[STG] || qy_reg[STG] > QLIM) ? QLIM : qy_reg[STG];
        dx_next = nx_reg[STG] ? -$signed({1'b0, magx}) : $signed({1'b0, magx});
        dy_next = ny_reg[STG] ? -$signed({1'b0, magy}) : $signed({1'b0, magy});
    end

    always_ff @(posedge clk)
    begin
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        side_reg <= sd_reg[STG];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            v_reg         <= {v_reg[STG-1:0], in_valid};
            out_valid_reg <= v_reg[STG];
        end
    end

    assign out_valid = out_valid_reg;
    assign dx = dx_reg;
    assign dy = dy_reg;
    assign side_out = side_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/ppr_norm.sv =====
// Two-stage normalizer forming floor(2*pix*65536/SIZE) - 65536 by reciprocal multiply.
`default_nettype none
module ppr_norm #(
    parameter int SIZE = 1280
) (
    input  logic                                    clk,
    input  logic [$clog2(SIZE)-1:0]                 pix,
    output logic signed [ppr_pkg::NORM_W-1:0]       norm
);
    import ppr_pkg::*;

    localparam int PW = $clog2(SIZE);
    localparam int PRW = PW + 27;
    localparam int RECIP = (2 ** 30) / SIZE;
    localparam int NW = 31;

    logic [PRW-1:0]   prod_reg;
    logic [PW-1:0]    pix_reg;
    logic [17:0]      q_est;
    logic [NW-1:0]    qw;
    logic [NW-1:0]    rem;
    logic [17:0]      q;
    logic signed [NORM_W-1:0] norm_next;
    logic signed [NORM_W-1:0] norm_reg;

    always_comb
    begin
        q_est = prod_reg[30:13];
        qw = NW'(q_est) * NW'(SIZE);
        rem = NW'({pix_reg, 17'b0}) - qw;
        q = q_est + 18'(rem >= NW'(SIZE));
        norm_next = $signed(NORM_W'(q - 18'd65536));
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= PRW'(pix) * PRW'(RECIP);
        pix_reg  <= pix;
        norm_reg <= norm_next;
    end

    assign norm = norm_reg;

endmodule
`default_nettype wire
